FILE: hw/rtl/dmfir_pkg.sv
// Shared types, codes and coefficient tables for the dual-mode FIR input filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmfir_pkg;

  localparam int SHORT_TAPS_DEF = 61;
  localparam int LONG_TAPS_DEF  = 135;
  localparam int COEF_FRAC_DEF  = 16;

  localparam int SAMPLE_W  = 16;
  localparam int RECIP_W   = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [RECIP_W-1:0] SHORT_RECIP_RST = 16'd8828;
  localparam logic [RECIP_W-1:0] LONG_RECIP_RST  = 16'd4214;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_RECIP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_RECIP  = 1'b1;

  localparam logic [CMD_W-1:0] CMD_SHORT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LONG  = 2'd1;

  typedef enum logic [1:0] {
    MODE_SHORT,
    MODE_LONG,
    MODE_BYPASS
  } mode_t;

  typedef struct packed {
    mode_t                       mode;
    logic signed [SAMPLE_W-1:0]  sample;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_MUL,
    ST_SUM,
    ST_MAG,
    ST_DONE
  } back_state_t;

  // Q2.16 table entries
  localparam int BASE_COEF_W = 18;
  localparam int SHORT_HALF  = 31;
  localparam int LONG_HALF   = 68;

  localparam logic signed [BASE_COEF_W-1:0] SHORT_HALF_COEF [SHORT_HALF] = '{
    -18'sd548, -18'sd1740, -18'sd2806, -18'sd3523, -18'sd3697, -18'sd3206, -18'sd2032,
    -18'sd284, 18'sd1805, 18'sd3902, 18'sd5620, 18'sd6577, 18'sd6468, 18'sd5130,
    18'sd2593, -18'sd896, -18'sd4878, -18'sd8728, -18'sd11724, -18'sd13146,
    -18'sd12384, -18'sd9034, -18'sd2982, 18'sd5554, 18'sd16023, 18'sd27586,
    18'sd39206, 18'sd49766, 18'sd58206, 18'sd63654, 18'sd65536
  };

  localparam logic signed [BASE_COEF_W-1:0] LONG_HALF_COEF [LONG_HALF] = '{
    18'sd2062, 18'sd2081, 18'sd1992, 18'sd1793, 18'sd1485, 18'sd1073, 18'sd573, 18'sd0,
    -18'sd621, -18'sd1262, -18'sd1895, -18'sd2486, -18'sd3003, -18'sd3416, -18'sd3694,
    -18'sd3816, -18'sd3761, -18'sd3520, -18'sd3088, -18'sd2473, -18'sd1689, -18'sd760,
    18'sd281, 18'sd1393, 18'sd2530, 18'sd3641, 18'sd4670, 18'sd5563, 18'sd6268,
    18'sd6737, 18'sd6929, 18'sd6812, 18'sd6366, 18'sd5584, 18'sd4472, 18'sd3053,
    18'sd1365, -18'sd540, -18'sd2596, -18'sd4724, -18'sd6836, -18'sd8837, -18'sd10627,
    -18'sd12107, -18'sd13179, -18'sd13754, -18'sd13752, -18'sd13107, -18'sd11772,
    -18'sd9718, -18'sd6936, -18'sd3444, 18'sd722, 18'sd5499, 18'sd10804, 18'sd16533,
    18'sd22566, 18'sd28769, 18'sd34996, 18'sd41098, 18'sd46924, 18'sd52324, 18'sd57161,
    18'sd61308, 18'sd64654, 18'sd67111, 18'sd68612, 18'sd69117
  };

  // Rescale a Q2.16 entry to frac fraction bits; narrowing rounds half away from zero.
  function automatic logic signed [31:0] scale_coef(logic signed [BASE_COEF_W-1:0] c,
                                                    int frac);
    logic signed [31:0] cx;
    logic [31:0]        mag;
    int                 sh;
    cx = 32'(c);
    if (frac >= 16) begin
      return cx <<< (frac - 16);
    end
    sh  = 16 - frac;
    mag = (cx < 0) ? 32'(-cx) : 32'(cx);
    mag = (mag + (32'd1 << (sh - 1))) >> sh;
    return (cx < 0) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dmfir_front.sv
// Front end: takes requests, decodes the command into a mode, holds a 2-entry queue.
// Depends on dmfir_pkg.
`default_nettype none

module dmfir_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dmfir_pkg::CMD_W-1:0]       command,
  input  wire logic signed [dmfir_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                              hold,
  output logic                                   q_valid,
  output dmfir_pkg::item_t                       q_item,
  input  wire logic                              pop
);
  import dmfir_pkg::*;

  item_t       q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  mode_t       mode;

  always_comb begin
    unique case (command)
      CMD_SHORT: mode = MODE_SHORT;
      CMD_LONG:  mode = MODE_LONG;
      default:   mode = MODE_BYPASS;
    endcase
  end

  assign in_stall = hold || (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{mode: mode, sample: sample_in};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dmfir_back.sv
// Back end: delay-line memories, shared MAC sequencer, gain scaling and output register.
// Depends on dmfir_pkg.
`default_nettype none

module dmfir_back #(
  parameter int SHORT_TAPS     = dmfir_pkg::SHORT_TAPS_DEF,
  parameter int LONG_TAPS      = dmfir_pkg::LONG_TAPS_DEF,
  parameter int COEF_FRAC_BITS = dmfir_pkg::COEF_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  output logic                                       hold,
  input  wire logic                                  q_valid,
  input  wire dmfir_pkg::item_t                      q_item,
  output logic                                       pop,
  input  wire logic                                  cfg_we,
  input  wire logic [dmfir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dmfir_pkg::RECIP_W-1:0]         cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dmfir_pkg::SAMPLE_W-1:0]      sample_out
);
  import dmfir_pkg::*;

  localparam int SP_W    = $clog2(SHORT_TAPS);
  localparam int LP_W    = $clog2(LONG_TAPS);
  localparam int CNT_W   = $clog2(LONG_TAPS);
  localparam int S_HALF  = (SHORT_TAPS + 1) / 2;
  localparam int L_HALF  = (LONG_TAPS + 1) / 2;
  localparam int SK_W    = $clog2(S_HALF);
  localparam int COEF_W  = (COEF_FRAC_BITS + 2 > BASE_COEF_W) ? COEF_FRAC_BITS + 2
                                                                : BASE_COEF_W;
  localparam int PROD_W  = SAMPLE_W + COEF_W;
  localparam int ACC_W   = PROD_W + 8;
  localparam int LO_W    = 23;
  localparam int HI_W    = ACC_W - LO_W;
  localparam int SCL_W   = ACC_W + RECIP_W + 1;
  localparam int SHIFT   = COEF_FRAC_BITS + 16;

  back_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] smem [SHORT_TAPS];
  logic signed [SAMPLE_W-1:0] lmem [LONG_TAPS];
  logic signed [SAMPLE_W-1:0] s_rdata, l_rdata;

  logic [RECIP_W-1:0]    short_recip, long_recip;
  item_t                 cur;
  logic [CNT_W-1:0]      clr;
  logic [SP_W-1:0]       sptr;
  logic [LP_W-1:0]       lptr;
  logic [CNT_W-1:0]      tap;
  logic [CNT_W-1:0]      raddr;
  logic                  v1, v2;
  logic signed [COEF_W-1:0] coef1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [LO_W+RECIP_W-1:0]  p_lo;
  logic signed [HI_W+RECIP_W:0] p_hi;
  logic signed [SCL_W-1:0]  scaled;
  logic                     neg;
  logic [SCL_W-1:0]         mag;

  logic                  s_we, l_we, issue, load_out;
  logic [CNT_W-1:0]      taps_m1, half, k;
  logic [SP_W-1:0]       sptr_inc;
  logic [LP_W-1:0]       lptr_inc;
  logic [RECIP_W-1:0]    recip;
  logic signed [BASE_COEF_W-1:0] coef_raw;
  logic signed [SAMPLE_W-1:0]    rdata;
  logic [SCL_W-1:0]      shifted;
  logic signed [SAMPLE_W-1:0]    result;

  always_comb begin
    taps_m1  = (cur.mode == MODE_LONG) ? CNT_W'(LONG_TAPS - 1) : CNT_W'(SHORT_TAPS - 1);
    half     = (cur.mode == MODE_LONG) ? CNT_W'(L_HALF) : CNT_W'(S_HALF);
    k        = (tap < half) ? tap : taps_m1 - tap;
    coef_raw = (cur.mode == MODE_LONG) ? LONG_HALF_COEF[k[$clog2(L_HALF)-1:0]]
                                       : SHORT_HALF_COEF[k[SK_W-1:0]];
    recip    = (cur.mode == MODE_LONG) ? long_recip : short_recip;
    rdata    = (cur.mode == MODE_LONG) ? l_rdata : s_rdata;
    sptr_inc = (sptr == SP_W'(SHORT_TAPS - 1)) ? '0 : sptr + 1'b1;
    lptr_inc = (lptr == LP_W'(LONG_TAPS - 1)) ? '0 : lptr + 1'b1;
    shifted  = mag >> SHIFT;
    // truncation toward zero done on the magnitude, then clamp
    if (cur.mode == MODE_BYPASS) begin
      result = cur.sample;
    end else if (neg) begin
      result = (shifted > SCL_W'(32768)) ? -16'sd32768 : SAMPLE_W'(-shifted);
    end else begin
      result = (shifted > SCL_W'(32767)) ? 16'sd32767 : SAMPLE_W'(shifted);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr == CNT_W'(LONG_TAPS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) begin
        state_next = (q_item.mode == MODE_BYPASS) ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: state_next = ST_MAC;
      ST_MAC:   if (tap == taps_m1) state_next = ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_MAG;
      ST_MAG:   state_next = ST_DONE;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    hold     = (state == ST_CLEAR);
    pop      = (state == ST_IDLE) && q_valid;
    issue    = (state == ST_MAC);
    load_out = (state == ST_DONE) && (!out_valid || !out_stall);
    s_we     = ((state == ST_CLEAR) && (clr < CNT_W'(SHORT_TAPS)))
            || ((state == ST_WRITE) && (cur.mode == MODE_SHORT));
    l_we     = (state == ST_CLEAR) || ((state == ST_WRITE) && (cur.mode == MODE_LONG));
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[hold ? clr[SP_W-1:0] : sptr] <= hold ? '0 : cur.sample;
    s_rdata <= smem[raddr[SP_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[hold ? clr[LP_W-1:0] : lptr] <= hold ? '0 : cur.sample;
    l_rdata <= lmem[raddr[LP_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    coef1  <= COEF_W'(scale_coef(coef_raw, COEF_FRAC_BITS));
    prod   <= rdata * coef1;
    p_lo   <= acc[LO_W-1:0] * recip;
    p_hi   <= $signed(acc[ACC_W-1:LO_W]) * $signed({1'b0, recip});
    scaled <= (SCL_W'(p_hi) <<< LO_W) + SCL_W'(p_lo);
    neg    <= scaled[SCL_W-1];
    mag    <= scaled[SCL_W-1] ? SCL_W'(-scaled) : SCL_W'(scaled);
    if (load_out) sample_out <= result;
    if (state == ST_WRITE) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == ST_WRITE) begin
      tap   <= '0;
      raddr <= (cur.mode == MODE_LONG) ? CNT_W'(lptr_inc) : CNT_W'(sptr_inc);
    end else if (issue) begin
      tap   <= tap + 1'b1;
      raddr <= (raddr == taps_m1) ? '0 : raddr + 1'b1;
    end
    if (rst) begin
      state       <= ST_CLEAR;
      clr         <= '0;
      sptr        <= '0;
      lptr        <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      out_valid   <= 1'b0;
      short_recip <= SHORT_RECIP_RST;
      long_recip  <= LONG_RECIP_RST;
    end else begin
      state <= state_next;
      if (hold) clr <= clr + 1'b1;
      if (s_we && !hold) sptr <= sptr_inc;
      if (l_we && !hold) lptr <= lptr_inc;
      v1 <= issue;
      v2 <= v1;
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHORT_RECIP: short_recip <= cfg_data;
          REG_LONG_RECIP:  long_recip  <= cfg_data;
          default:         short_recip <= short_recip;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dual_mode_fir_input_filter_top.sv
// Top level of the dual-mode FIR input filter: front queue plus MAC back end.
// Depends on dmfir_pkg, dmfir_front, dmfir_back.
//
//   channel | signals                               | role
//   in      | in_valid, in_stall, command, sample_in | request in
//   out     | out_valid, out_stall, sample_out       | result out
//   cfg     | cfg_we, cfg_index, cfg_data            | gain reciprocal writes
//
// One shared multiplier walks the selected delay line, one tap per cycle.
// A bypass request skips the MAC walk and goes straight to the output register.
// After reset a clearing pass zeroes both delay lines; in_stall is high throughout it.
// The 2-entry queue keeps taking requests, until it is full, while the back end works or out is stalled.
`default_nettype none

module dual_mode_fir_input_filter_top #(
  parameter int SHORT_TAPS     = dmfir_pkg::SHORT_TAPS_DEF,
  parameter int LONG_TAPS      = dmfir_pkg::LONG_TAPS_DEF,
  parameter int COEF_FRAC_BITS = dmfir_pkg::COEF_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [dmfir_pkg::CMD_W-1:0]           command,
  input  wire logic signed [dmfir_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dmfir_pkg::SAMPLE_W-1:0]      sample_out,
  input  wire logic                                  cfg_we,
  input  wire logic [dmfir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dmfir_pkg::RECIP_W-1:0]         cfg_data
);
  import dmfir_pkg::*;

  logic  hold;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  dmfir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample_in (sample_in),
    .hold      (hold),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  dmfir_back #(
    .SHORT_TAPS     (SHORT_TAPS),
    .LONG_TAPS      (LONG_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .hold       (hold),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the dual-mode FIR input filter (61-tap, 135-tap, bypass).
// Depends on dmfir_pkg and dual_mode_fir_input_filter_top; predicts every output in a
// scoreboard class and drives random idling, stalls and gain settings.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmfir_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BYPASS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 700;
  localparam int SETTLE      = 200;

  // Tracks both delay lines and the gains; holds the results still owed.
  class fir_scoreboard;
    shortint short_line[SHORT_TAPS_DEF];
    shortint long_line[LONG_TAPS_DEF];
    logic [RECIP_W-1:0] short_recip = SHORT_RECIP_RST;
    logic [RECIP_W-1:0] long_recip  = LONG_RECIP_RST;
    shortint owed[$];

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [RECIP_W-1:0] val);
      if (idx == REG_SHORT_RECIP) short_recip = val;
      else long_recip = val;
    endfunction

    function shortint filter(bit use_long, shortint s);
      longint acc, prod, mag;
      int taps, k;
      taps = use_long ? LONG_TAPS_DEF : SHORT_TAPS_DEF;
      acc = 0;
      for (int i = 0; i < taps - 1; i++) begin
        if (use_long) long_line[i] = long_line[i+1];
        else short_line[i] = short_line[i+1];
      end
      if (use_long) long_line[taps-1] = s;
      else short_line[taps-1] = s;
      for (int i = 0; i < taps; i++) begin
        k = (i < (taps + 1) / 2) ? i : taps - 1 - i;
        if (use_long) acc += longint'(LONG_HALF_COEF[k]) * longint'(long_line[i]);
        else acc += longint'(SHORT_HALF_COEF[k]) * longint'(short_line[i]);
      end
      prod = acc * longint'({1'b0, use_long ? long_recip : short_recip});
      mag = (prod < 0) ? -prod : prod;
      mag = mag >>> 32;
      if (prod < 0) return (mag > 32768) ? -32768 : shortint'(-mag);
      return (mag > 32767) ? 32767 : shortint'(mag);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, shortint s);
      if (cmd == CMD_SHORT) owed.push_back(filter(1'b0, s));
      else if (cmd == CMD_LONG) owed.push_back(filter(1'b1, s));
      else owed.push_back(s);
    endfunction

    // Returns 0 on mismatch or when nothing was owed.
    function bit check_result(shortint got, output shortint want, output bit stray);
      stray = (owed.size() == 0);
      if (stray) return 0;
      want = owed.pop_front();
      return got == want;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = CMD_BYPASS;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_RECIP;
  logic [RECIP_W-1:0] cfg_data = '0;

  fir_scoreboard sb = new();
  int errors = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  dual_mode_fir_input_filter_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(string what, shortint got, shortint want);
    errors++;
    $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Output side: checks, random stall, long hold-off on request, watchdog.
  always @(posedge clk) begin
    shortint want;
    bit stray;
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_result(sample_out, want, stray)) begin
        if (stray) report("unexpected result", sample_out, 0);
        else report("sample_out", sample_out, want);
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, shortint s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, s);
  endtask

  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [RECIP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_gain(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic shortint pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return shortint'($urandom_range(16'hffff));
    endcase
  endfunction

  // Mostly runs of one filter so the delay lines fill; bypass and spare code mixed in.
  task automatic random_phase(int n);
    logic [CMD_W-1:0] cmd;
    int run;
    while (n > 0) begin
      cmd = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3));
      run = $urandom_range(1, 40);
      for (int i = 0; i < run && n > 0; i++, n--) send(cmd, pick_sample());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, both delay lines fed with full-scale samples
    for (int i = 0; i < 6; i++) send(CMD_SHORT, 16'sh7fff);
    for (int i = 0; i < 6; i++) send(CMD_LONG, 16'sh8000);
    send(CMD_BYPASS, 16'sh7fff);
    send(CMD_BYPASS, 16'sh8000);
    send(CMD_SPARE, 16'sh1234);
    send(CMD_SHORT, 16'sh0000);
    send(CMD_LONG, 16'shffff);
    send(CMD_SHORT, 16'sh8000);
    send(CMD_LONG, 16'sh0001);
    send(CMD_SPARE, 16'sh8000);
    drain();

    snd_idle_pct = 34; rcv_idle_pct = 77;
    write_gain(REG_SHORT_RECIP, 16'hffff);
    write_gain(REG_LONG_RECIP, 16'hffff);
    random_phase(130);
    drain();

    write_gain(REG_SHORT_RECIP, 16'd1);
    write_gain(REG_LONG_RECIP, 16'd0);
    random_phase(120);
    drain();

    snd_idle_pct = 77; rcv_idle_pct = 34;
    write_gain(REG_SHORT_RECIP, 16'd0);
    write_gain(REG_LONG_RECIP, 16'd1);
    random_phase(120);
    drain();

    snd_idle_pct = 0; rcv_idle_pct = 0;
    write_gain(REG_SHORT_RECIP, 16'($urandom_range(1, 16'hffff)));
    write_gain(REG_LONG_RECIP, 16'($urandom_range(1, 16'hffff)));
    hold_req = 1;  // output held off while requests keep coming
    random_phase(130);
    drain();

    write_gain(REG_SHORT_RECIP, SHORT_RECIP_RST);
    write_gain(REG_LONG_RECIP, 16'hffff);
    random_phase(130);
    drain();

    if (errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.owed.size() != 0) report("results missing", 0, 0);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/dmfir_pkg.sv
hw/rtl/dmfir_front.sv
hw/rtl/dmfir_back.sv
hw/rtl/dual_mode_fir_input_filter_top.sv
tb/sv/testbench.sv
